/* rtl/matrix_keypad_scanner_unit_assert.svh */
// Assertion macros for the matrix keypad scanner unit.
// Bodies are empty when SYNTHESIS is defined; the macros sample on aclk and reset on aresetn.
`ifndef MATRIX_KEYPAD_SCANNER_UNIT_ASSERT_SVH
`define MATRIX_KEYPAD_SCANNER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define MKS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("keypad scanner assertion failed");
// Next-cycle implication.
`define MKS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("keypad scanner assertion failed");
`else
`define MKS_ASSERT_IMP(label, ante, cons)
`define MKS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* rtl/mks_pkg.sv */
// Shared types, key tables and constants of the matrix keypad scanner.
// No dependencies; used by mks_step and matrix_keypad_scanner_unit.
package mks_pkg;

    localparam int unsigned DELAY_W = 16;
    localparam logic [DELAY_W-1:0] DEBOUNCE_RESET = 16'd500;

    typedef enum logic [5:0] {
        MODE_IDLE    = 6'b000001,
        MODE_SETTLE  = 6'b000010,
        MODE_PROBE   = 6'b000100,
        MODE_CONFIRM = 6'b001000,
        MODE_RETRY   = 6'b010000,
        MODE_RELEASE = 6'b100000
    } mode_t;

    // Low nibble: rows driven; high nibble: columns expected when the key is down.
    localparam logic [7:0] KEY_TABLE [16] = '{
        8'h77, 8'h7B, 8'h7D, 8'h7E,
        8'hB7, 8'hBB, 8'hBD, 8'hBE,
        8'hD7, 8'hDB, 8'hDD, 8'hDE,
        8'hE7, 8'hEB, 8'hED, 8'hEE
    };

    // ASCII legends: 1 2 3 A / 4 5 6 B / 7 8 9 C / E 0 F D.
    localparam logic [6:0] CHAR_TABLE [16] = '{
        7'h31, 7'h32, 7'h33, 7'h41,
        7'h34, 7'h35, 7'h36, 7'h42,
        7'h37, 7'h38, 7'h39, 7'h43,
        7'h45, 7'h30, 7'h46, 7'h44
    };

    typedef struct packed {
        mode_t              mode;
        logic [3:0]         pattern_index;
        logic [DELAY_W-1:0] delay_count;
        logic [3:0]         last_columns;
        logic [3:0]         drive_pattern;
    } scan_state_t;

    typedef struct packed {
        logic [3:0] row_drive;
        logic       scan_done;
        logic       key_found;
        logic [4:0] key_id;
        logic [6:0] key_char;
    } scan_result_t;

endpackage

/* rtl/mks_step.sv */
// One tick of the keypad scan controller: next state and result from the current state.
// Depends on mks_pkg.
module mks_step
    import mks_pkg::*;
(
    input  scan_state_t        cur,
    input  logic [3:0]         column_sample,
    input  logic [DELAY_W-1:0] debounce_ticks,
    output scan_state_t        nxt,
    output scan_result_t       res
);

    logic [3:0] expected;
    logic       advance;
    logic       done;
    logic       delay_open;

    assign expected   = KEY_TABLE[cur.pattern_index][7:4];
    assign delay_open = cur.delay_count < debounce_ticks;

    always_comb begin
        nxt            = cur;
        advance        = 1'b0;
        done           = 1'b0;
        res.key_found  = 1'b0;
        res.key_id     = '0;
        res.key_char   = '0;

        unique case (cur.mode)
            MODE_SETTLE: begin
                if (delay_open) begin
                    nxt.delay_count = cur.delay_count + 1'b1;
                end else begin
                    nxt.pattern_index = '0;
                    nxt.drive_pattern = KEY_TABLE[0][3:0];
                    nxt.mode          = MODE_PROBE;
                end
            end
            MODE_PROBE: begin
                if (column_sample == expected) begin
                    nxt.delay_count = '0;
                    nxt.mode        = MODE_CONFIRM;
                end else begin
                    advance = 1'b1;
                end
            end
            MODE_CONFIRM: begin
                if (delay_open) begin
                    nxt.delay_count = cur.delay_count + 1'b1;
                end else if (column_sample == expected) begin
                    nxt.mode = MODE_RELEASE;
                end else begin
                    nxt.delay_count = '0;
                    nxt.mode        = MODE_RETRY;
                end
            end
            MODE_RETRY: begin
                if (delay_open) begin
                    nxt.delay_count = cur.delay_count + 1'b1;
                end else begin
                    advance = 1'b1;
                end
            end
            MODE_RELEASE: begin
                if (column_sample != expected) begin
                    done           = 1'b1;
                    res.key_found  = 1'b1;
                    res.key_id     = {1'b0, cur.pattern_index} + 5'd1;
                    res.key_char   = CHAR_TABLE[cur.pattern_index];
                end
            end
            default: begin
                // Idle: a falling edge on any column starts the debounce wait.
                nxt.mode          = MODE_IDLE;
                nxt.drive_pattern = '0;
                if ((cur.last_columns & ~column_sample) != 4'd0) begin
                    nxt.delay_count = '0;
                    nxt.mode        = MODE_SETTLE;
                end
            end
        endcase

        if (advance) begin
            if (cur.pattern_index == 4'd15) begin
                done = 1'b1;
            end else begin
                nxt.pattern_index = cur.pattern_index + 4'd1;
                nxt.drive_pattern = KEY_TABLE[cur.pattern_index + 4'd1][3:0];
                nxt.mode          = MODE_PROBE;
            end
        end

        if (done) begin
            nxt.mode          = MODE_IDLE;
            nxt.pattern_index = '0;
            nxt.delay_count   = '0;
            nxt.drive_pattern = '0;
        end

        nxt.last_columns = column_sample;
        res.row_drive    = nxt.drive_pattern;
        res.scan_done    = done;
    end

endmodule

/* rtl/matrix_keypad_scanner_unit.sv */
// Top level of the 4x4 matrix keypad scanner: stream channels, state and config register.
// Depends on mks_pkg, mks_step and matrix_keypad_scanner_unit_assert.svh.
//
// Usage: each transfer on the s_ channel carries one tick's column sample (active low,
// reflecting the row drive of the previous result). Each such transfer yields exactly one
// result transfer on the m_ channel with the row drive for this tick, the key number and
// its ASCII character; m_tlast marks the tick a scan finishes and m_tuser that a key was
// confirmed. The debounce delay is to be written through cfg_we/cfg_wdata only while the
// block idles; the block itself does not enforce this. An input transfer fills the input
// register; the state update and result then load into the output register together as
// soon as it is empty or being read, and m_tvalid rises with them. The block takes one item
// per cycle while m_tready stays high, as the state update between the two registers is
// combinational.
// When the receiver stalls, the finished result holds in the output register and one more
// input is still taken into the input register; s_tready then drops until m_tready returns.
// Synchronous reset (aresetn low) empties both registers, sets the scanner idle with all
// rows low and columns taken as released, and loads the debounce delay with 500 ticks.
module matrix_keypad_scanner_unit
    import mks_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [15:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [3:0] column_sample, [7:4] zero
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [15:0]  m_tdata,   // [3:0] row_drive, [8:4] key_id, [15:9] key_char
    output logic         m_tlast,   // scan_done
    output logic         m_tuser    // key_found
);

`include "matrix_keypad_scanner_unit_assert.svh"

    logic [DELAY_W-1:0] debounce_reg;
    scan_state_t        state_reg;
    scan_state_t        state_next;
    scan_result_t       result_next;
    scan_result_t       result_reg;
    logic               in_valid_reg;
    logic [3:0]         in_cols_reg;
    logic               out_valid_reg;
    logic               s_fire;
    logic               advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    mks_step u_step (
        .cur            (state_reg),
        .column_sample  (in_cols_reg),
        .debounce_ticks (debounce_reg),
        .nxt            (state_next),
        .res            (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg <= DEBOUNCE_RESET;
        end else if (cfg_we) begin
            debounce_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.mode          <= MODE_IDLE;
            state_reg.pattern_index <= '0;
            state_reg.delay_count   <= '0;
            state_reg.last_columns  <= 4'hF;
            state_reg.drive_pattern <= '0;
            in_valid_reg            <= 1'b0;
            out_valid_reg           <= 1'b0;
        end else begin
            if (s_fire) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_cols_reg <= s_tdata[3:0];
        end
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {result_reg.key_char, result_reg.key_id, result_reg.row_drive};
    assign m_tlast  = result_reg.scan_done;
    assign m_tuser  = result_reg.key_found;

    // A confirmed key always carries a key number and closes the scan.
    `MKS_ASSERT_IMP(a_found_has_key, m_tvalid && m_tuser, m_tlast && (m_tdata[8:4] != 5'd0))
    // With both registers full and the output stalled, no input may be taken.
    `MKS_ASSERT_IMP(a_full_blocks_input, in_valid_reg && out_valid_reg && !m_tready, !s_tready)
    // Once idle, the scanner sits at the first pattern with all rows low.
    `MKS_ASSERT_IMP(a_idle_clean, state_reg.mode == MODE_IDLE,
        (state_reg.pattern_index == 4'd0) && (state_reg.drive_pattern == 4'd0))

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for matrix_keypad_scanner_unit: a keypad model answers the row drive,
// a scoreboard class predicts every result transfer and compares it field by field.
// Depends on mks_pkg and the matrix_keypad_scanner_unit RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import mks_pkg::*;

    localparam int CLK_PERIOD = 10;
    localparam int RESET_CYCLES = 4;
    localparam int RANDOM_ITEMS = 900;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_GAP = 11;
    localparam int MAX_PRINTED = 40;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam logic [15:0] DEBOUNCE_AT_RESET = 16'd500;
    localparam logic [15:0] DEBOUNCE_MAX = 16'hFFFF;
    localparam logic [15:0] DEBOUNCE_MIN = 16'd0;
    localparam logic [3:0] COLS_RELEASED = 4'hF;
    localparam logic [3:0] LAST_PATTERN = 4'd15;

    class keypad_scoreboard;
        mode_t        mode;
        logic [3:0]   probe_index;
        logic [15:0]  wait_count;
        logic [3:0]   prev_columns;
        logic [3:0]   rows_driven;
        logic [15:0]  debounce;
        scan_result_t scans_due[$];
        int unsigned  errors;
        int unsigned  checked;
        string        legend;

        function new();
            legend = "123A456B789CE0FD";
            debounce = DEBOUNCE_AT_RESET;
            mode = MODE_IDLE;
            probe_index = '0;
            wait_count = '0;
            prev_columns = COLS_RELEASED;
            rows_driven = '0;
            errors = 0;
            checked = 0;
        endfunction

        // Key k sits on row line k%4 and column line k/4, counted from the top bit down.
        static function logic [3:0] rows_for(logic [3:0] k);
            logic [3:0] one_low;
            one_low = 4'b1000 >> k[1:0];
            return ~one_low;
        endfunction

        static function logic [3:0] cols_for(logic [3:0] k);
            logic [3:0] one_low;
            one_low = 4'b1000 >> k[3:2];
            return ~one_low;
        endfunction

        // Advances the scanner by one tick for an accepted column sample.
        function void note_columns(logic [3:0] cols);
            scan_result_t r;
            logic         advance;
            byte          ch;
            r = '0;
            advance = 1'b0;
            case (mode)
                MODE_SETTLE: begin
                    if (wait_count < debounce) begin
                        wait_count++;
                    end else begin
                        probe_index = '0;
                        rows_driven = rows_for(probe_index);
                        mode = MODE_PROBE;
                    end
                end
                MODE_PROBE: begin
                    if (cols == cols_for(probe_index)) begin
                        wait_count = '0;
                        mode = MODE_CONFIRM;
                    end else begin
                        advance = 1'b1;
                    end
                end
                MODE_CONFIRM: begin
                    if (wait_count < debounce) begin
                        wait_count++;
                    end else if (cols == cols_for(probe_index)) begin
                        mode = MODE_RELEASE;
                    end else begin
                        wait_count = '0;
                        mode = MODE_RETRY;
                    end
                end
                MODE_RETRY: begin
                    if (wait_count < debounce) wait_count++;
                    else advance = 1'b1;
                end
                MODE_RELEASE: begin
                    if (cols != cols_for(probe_index)) begin
                        ch = legend.getc(probe_index);
                        r.scan_done = 1'b1;
                        r.key_found = 1'b1;
                        r.key_id = {1'b0, probe_index} + 5'd1;
                        r.key_char = ch[6:0];
                    end
                end
                default: begin
                    mode = MODE_IDLE;
                    rows_driven = '0;
                    if ((prev_columns & ~cols) != 4'd0) begin
                        wait_count = '0;
                        mode = MODE_SETTLE;
                    end
                end
            endcase
            if (advance) begin
                if (probe_index == LAST_PATTERN) begin
                    r.scan_done = 1'b1;
                end else begin
                    probe_index++;
                    rows_driven = rows_for(probe_index);
                    mode = MODE_PROBE;
                end
            end
            if (r.scan_done) begin
                mode = MODE_IDLE;
                probe_index = '0;
                wait_count = '0;
                rows_driven = '0;
            end
            prev_columns = cols;
            r.row_drive = rows_driven;
            scans_due.push_back(r);
        endfunction

        task report(string msg);
            if (errors < MAX_PRINTED) $display("MISMATCH: %s", msg);
            errors++;
        endtask

        task compare_field(string field, logic [15:0] got, logic [15:0] want);
            if (got !== want)
                report($sformatf("result %0d %s: got %0h, wanted %0h", checked, field, got, want));
        endtask

        task check_result(scan_result_t got);
            scan_result_t want;
            if (scans_due.size() == 0) begin
                report($sformatf("result %0d arrived with no tick outstanding", checked));
            end else begin
                want = scans_due.pop_front();
                compare_field("row_drive", 16'(got.row_drive), 16'(want.row_drive));
                compare_field("scan_done", 16'(got.scan_done), 16'(want.scan_done));
                compare_field("key_found", 16'(got.key_found), 16'(want.key_found));
                compare_field("key_id", 16'(got.key_id), 16'(want.key_id));
                compare_field("key_char", 16'(got.key_char), 16'(want.key_char));
            end
            checked++;
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;      // [3:0] column_sample, [7:4] zero
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;           // [3:0] row_drive, [8:4] key_id, [15:9] key_char
    logic        m_tlast;           // scan_done
    logic        m_tuser;           // key_found

    keypad_scoreboard sb = new();
    int unsigned items_sent = 0;
    int unsigned cycle_count = 0;
    bit          send_steady = 1'b0;
    bit          sink_steady = 1'b0;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    matrix_keypad_scanner_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    // Column pins seen with the given keys held down and the given rows driven low.
    function automatic logic [3:0] keypad_columns(logic [15:0] pressed, logic [3:0] rows);
        logic [3:0] cols;
        cols = COLS_RELEASED;
        for (int k = 0; k < 16; k++)
            if (pressed[k] && !rows[3 - (k % 4)]) cols[3 - (k / 4)] = 1'b0;
        return cols;
    endfunction

    task automatic send_columns(logic [3:0] cols);
        int unsigned gap;
        if ($urandom_range(0, 31) == 0) send_steady = !send_steady;
        gap = send_steady ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata <= {4'b0000, cols};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        sb.note_columns(cols);
        items_sent++;
    endtask

    // Holds the keys until the scanner waits for release or the cap runs out, then lets go
    // and runs until the scanner is idle again.
    task automatic hold_keys(logic [15:0] pressed, int unsigned cap, bit noisy);
        int unsigned n;
        logic [3:0]  cols;
        n = 0;
        while (n < cap && sb.mode != MODE_RELEASE) begin
            if (noisy && $urandom_range(0, 3) == 0) cols = 4'($urandom_range(0, 15));
            else cols = keypad_columns(pressed, sb.rows_driven);
            send_columns(cols);
            n++;
        end
        if (sb.mode == MODE_RELEASE)
            repeat ($urandom_range(0, 3)) send_columns(keypad_columns(pressed, sb.rows_driven));
        while (sb.mode != MODE_IDLE) send_columns(COLS_RELEASED);
    endtask

    task automatic run_press(int unsigned debounce);
        int unsigned kind;
        int unsigned key;
        int unsigned cap;
        logic [15:0] one_key;
        kind = $urandom_range(0, 9);
        key = $urandom_range(0, 15);
        one_key = 16'd1 << key;
        cap = 2 * debounce + 22;
        case (kind)
            6: hold_keys(one_key, $urandom_range(1, cap), 1'b0);
            7: hold_keys(one_key | (16'd1 << $urandom_range(0, 15)), cap, 1'b0);
            8: hold_keys(16'd0, $urandom_range(1, 8), 1'b1);
            9: hold_keys(one_key, cap, 1'b1);
            default: hold_keys(one_key, cap, 1'b0);
        endcase
        repeat ($urandom_range(0, 2)) send_columns(COLS_RELEASED);
    endtask

    // Waits until every result is back and the pipeline is quiet before touching the register.
    task automatic write_debounce(logic [15:0] value);
        s_tvalid <= 1'b0;
        while (sb.scans_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_wdata <= value;
        cfg_we <= 1'b1;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.debounce = value;
    endtask

    initial begin : result_sink
        scan_result_t got;
        int unsigned  stall;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if ($urandom_range(0, 31) == 0) sink_steady = !sink_steady;
            stall = sink_steady ? 0 : $urandom_range(0, MAX_GAP);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            got.row_drive = m_tdata[3:0];
            got.key_id = m_tdata[8:4];
            got.key_char = m_tdata[15:9];
            got.scan_done = m_tlast;
            got.key_found = m_tuser;
            sb.check_result(got);
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("matrix_keypad_scanner_unit verification failed");
        $finish;
    end

    initial begin : stimulus
        int unsigned random_start;
        int unsigned phase;
        logic [15:0] debounce;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Column extremes and edges under the reset debounce; the scan stays in its settle wait.
        send_columns(COLS_RELEASED);
        send_columns(4'h0);
        send_columns(COLS_RELEASED);
        send_columns(4'h0);
        send_columns(4'hA);
        send_columns(4'h5);

        // Zero delay: a clean press of the first key, then a press lost during confirmation.
        write_debounce(DEBOUNCE_MIN);
        hold_keys(16'h0001, 12, 1'b0);
        hold_keys(16'h0001, 3, 1'b0);

        random_start = items_sent;
        phase = 0;
        while (items_sent - random_start < RANDOM_ITEMS) begin
            if (phase == 2) begin
                // The longest delay never finishes its settle wait within this phase.
                write_debounce(DEBOUNCE_MAX);
                repeat (30)
                    send_columns(keypad_columns(16'd1 << $urandom_range(0, 15), sb.rows_driven));
            end else begin
                case ($urandom_range(0, 4))
                    0: debounce = DEBOUNCE_MIN;
                    1, 2: debounce = 16'($urandom_range(1, 3));
                    3: debounce = 16'($urandom_range(4, 7));
                    default: debounce = 16'($urandom_range(8, 20));
                endcase
                write_debounce(debounce);
                repeat (4) run_press(debounce);
            end
            phase++;
        end

        s_tvalid <= 1'b0;
        while (sb.scans_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("matrix_keypad_scanner_unit verification clean");
        end else begin
            $display("matrix_keypad_scanner_unit verification failed");
        end
        $finish;
    end

endmodule

/* matrix_keypad_scanner_unit.f */
+incdir+rtl
rtl/mks_pkg.sv
rtl/mks_step.sv
rtl/matrix_keypad_scanner_unit.sv
tb/sv/tb_top.sv
